[src/assert_macros.svh]
// concurrent assertion helpers, clocked on clk_i and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define HRVW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define HRVW_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define HRVW_ASSERT(lbl, prop, msg)
`define HRVW_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

[src/hrvw_pkg.sv]
package hrvw_pkg;

  localparam int unsigned IntervalW  = 16;
  localparam int unsigned RegW       = 16;
  localparam int unsigned RegIdxW    = 3;
  localparam int unsigned SdW        = 20;
  localparam int unsigned ClassW     = 2;
  // squared values carry 8 fraction bits, roots 4 (sixteenths)
  localparam int unsigned SqFracShift    = 8;
  localparam int unsigned SixteenthShift = 4;
  // q0.16 limit against sixteenths: 65536 / 16
  localparam int unsigned CovShift       = 12;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  typedef enum logic [RegIdxW-1:0] {
    REG_MIN_INTERVAL  = 3'd0,
    REG_MAX_INTERVAL  = 3'd1,
    REG_FAST_MEAN     = 3'd2,
    REG_SLOW_MEAN     = 3'd3,
    REG_VARIATION     = 3'd4,
    REG_LOW_STRESS    = 3'd5,
    REG_MODERATE_STRESS = 3'd6,
    REG_HIGH_STRESS   = 3'd7
  } reg_idx_e;

  typedef enum logic [ClassW-1:0] {
    RHYTHM_NORMAL    = 2'd0,
    RHYTHM_TACHY     = 2'd1,
    RHYTHM_BRADY     = 2'd2,
    RHYTHM_IRREGULAR = 2'd3
  } rhythm_e;

  typedef enum logic [ClassW-1:0] {
    STRESS_LOW       = 2'd0,
    STRESS_MODERATE  = 2'd1,
    STRESS_HIGH      = 2'd2,
    STRESS_VERY_HIGH = 2'd3
  } stress_e;

  typedef enum logic {
    OP_DIV  = 1'b0,
    OP_SQRT = 1'b1
  } ds_op_e;

  typedef struct packed {
    logic [RegW-1:0] min_interval;
    logic [RegW-1:0] max_interval;
    logic [RegW-1:0] fast_mean_limit;
    logic [RegW-1:0] slow_mean_limit;
    logic [RegW-1:0] variation_limit;
    logic [RegW-1:0] low_stress_sdnn;
    logic [RegW-1:0] moderate_stress_sdnn;
    logic [RegW-1:0] high_stress_sdnn;
  } cfg_regs_t;

  localparam cfg_regs_t CfgReset = '{
    min_interval:         16'd250,
    max_interval:         16'd2000,
    fast_mean_limit:      16'd500,
    slow_mean_limit:      16'd1200,
    variation_limit:      16'd11796,
    low_stress_sdnn:      16'd50,
    moderate_stress_sdnn: 16'd30,
    high_stress_sdnn:     16'd20
  };

  typedef struct packed {
    logic [IntervalW-1:0] interval_ms;
  } in_item_t;

  typedef struct packed {
    logic              accepted;
    logic              valid_res;
    logic [SdW-1:0]    sdnn_sixteenths;
    logic [SdW-1:0]    rmssd_sixteenths;
    logic [ClassW-1:0] rhythm_class;
    logic [ClassW-1:0] stress_class;
  } out_item_t;

  typedef struct packed {
    logic [IntervalW-1:0] interval_ms;
    logic                 accepted;
  } queue_item_t;

endpackage

[src/hrvw_stream_if.sv]
interface hrvw_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/hrvw_front.sv]
module hrvw_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [hrvw_pkg::RegIdxW-1:0] cfg_idx_i,
  input  logic [hrvw_pkg::RegW-1:0]   cfg_data_i,
  hrvw_stream_if.sink                 in_if,
  output logic                        push_valid_o,
  input  logic                        push_ready_i,
  output hrvw_pkg::queue_item_t       push_item_o,
  output hrvw_pkg::cfg_regs_t         cfg_o
);
  import hrvw_pkg::*;

  cfg_regs_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_MIN_INTERVAL:    cfg_q.min_interval         <= cfg_data_i;
        REG_MAX_INTERVAL:    cfg_q.max_interval         <= cfg_data_i;
        REG_FAST_MEAN:       cfg_q.fast_mean_limit      <= cfg_data_i;
        REG_SLOW_MEAN:       cfg_q.slow_mean_limit      <= cfg_data_i;
        REG_VARIATION:       cfg_q.variation_limit      <= cfg_data_i;
        REG_LOW_STRESS:      cfg_q.low_stress_sdnn      <= cfg_data_i;
        REG_MODERATE_STRESS: cfg_q.moderate_stress_sdnn <= cfg_data_i;
        REG_HIGH_STRESS:     cfg_q.high_stress_sdnn     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o        = cfg_q;
  assign in_if.ready  = push_ready_i;
  assign push_valid_o = in_if.valid;

  // range check decides whether the item enters the window
  assign push_item_o.interval_ms = in_if.data.interval_ms;
  assign push_item_o.accepted    = (in_if.data.interval_ms >= cfg_q.min_interval) &&
                                   (in_if.data.interval_ms <= cfg_q.max_interval);
endmodule

[src/hrvw_queue.sv]
module hrvw_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  output logic                  push_ready_o,
  input  hrvw_pkg::queue_item_t push_item_i,
  output logic                  pop_valid_o,
  input  logic                  pop_ready_i,
  output hrvw_pkg::queue_item_t pop_item_o
);
  import hrvw_pkg::*;

  queue_item_t      slot_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q;
  logic [QPtrW-1:0] rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             push;
  logic             pop;

  assign push_ready_o = (cnt_q != QCntW'(QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end
endmodule

[src/hrvw_divsqrt.sv]
module hrvw_divsqrt #(
  parameter int unsigned DvW = 52,
  parameter int unsigned DsW = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  hrvw_pkg::ds_op_e       op_i,
  input  logic [DvW-1:0]         a_i,
  input  logic [DsW-1:0]         b_i,
  output logic                   done_o,
  output logic [DvW-1:0]         quo_o,
  output logic [(DvW+1)/2-1:0]   root_o
);
  import hrvw_pkg::*;

  localparam int unsigned RtW  = (DvW + 1) / 2;
  localparam int unsigned RadW = 2 * RtW;
  localparam int unsigned CntW = $clog2(DvW + 1);

  logic            busy_q;
  logic            done_q;
  ds_op_e          op_q;
  logic [CntW-1:0] cnt_q;
  logic [DvW-1:0]  quo_q;
  logic [DsW-1:0]  rem_q;
  logic [DsW-1:0]  dsr_q;
  logic [RadW-1:0] rad_q;
  logic [RtW-1:0]  root_q;
  logic [RtW:0]    srem_q;

  logic [DsW:0]    div_sh;
  logic [DsW:0]    div_sub;
  logic            div_ge;
  logic [RtW+2:0]  sq_rem4;
  logic [RtW+2:0]  sq_trial;
  logic [RtW+2:0]  sq_sub;
  logic            sq_ge;

  // restoring division, one quotient bit per cycle
  assign div_sh  = {rem_q, quo_q[DvW-1]};
  assign div_ge  = div_sh >= {1'b0, dsr_q};
  assign div_sub = div_sh - {1'b0, dsr_q};

  // digit-by-digit root, two radicand bits per cycle
  assign sq_rem4  = {srem_q, rad_q[RadW-1 -: 2]};
  assign sq_trial = {(RtW+1)'(root_q), 2'b01};
  assign sq_ge    = sq_rem4 >= sq_trial;
  assign sq_sub   = sq_rem4 - sq_trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_DIV;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      dsr_q  <= '0;
      rad_q  <= '0;
      root_q <= '0;
      srem_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        op_q   <= op_i;
        if (op_i == OP_DIV) begin
          quo_q <= a_i;
          rem_q <= '0;
          dsr_q <= b_i;
          cnt_q <= CntW'(DvW);
        end else begin
          rad_q  <= RadW'(a_i);
          root_q <= '0;
          srem_q <= '0;
          cnt_q  <= CntW'(RtW);
        end
      end else if (busy_q) begin
        if (op_q == OP_DIV) begin
          rem_q <= div_ge ? div_sub[DsW-1:0] : div_sh[DsW-1:0];
          quo_q <= {quo_q[DvW-2:0], div_ge};
        end else begin
          srem_q <= sq_ge ? sq_sub[RtW:0] : sq_rem4[RtW:0];
          root_q <= {root_q[RtW-2:0], sq_ge};
          rad_q  <= {rad_q[RadW-3:0], 2'b00};
        end
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign root_o = root_q;
endmodule

[src/hrvw_back.sv]
`include "assert_macros.svh"
module hrvw_back #(
  parameter int unsigned WINDOW_DEPTH  = 32,
  parameter int unsigned MIN_INTERVALS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  pop_valid_i,
  output logic                  pop_ready_o,
  input  hrvw_pkg::queue_item_t pop_item_i,
  input  hrvw_pkg::cfg_regs_t   cfg_i,
  hrvw_stream_if.source         out_if
);
  import hrvw_pkg::*;

  localparam int unsigned CntW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned PtrW = $clog2(WINDOW_DEPTH);
  localparam int unsigned SumW = IntervalW + CntW;
  localparam int unsigned SqW  = 2 * IntervalW + CntW;
  localparam int unsigned VarW = SqW + CntW;
  localparam int unsigned DvW  = VarW + SqFracShift;
  localparam int unsigned DsW  = 2 * CntW;
  localparam int unsigned RtW  = (DvW + 1) / 2;
  localparam int unsigned MulW = (SumW > SdW) ? SumW : SdW;
  localparam int unsigned PrdW = 2 * MulW;
  localparam int unsigned CmpW = PrdW + CovShift;

  typedef enum logic [4:0] {
    S_IDLE, S_RD_PREV, S_RD_OLD, S_RD_NXT, S_UPD_PREV, S_UPD_OLD, S_UPD_NXT,
    S_STAT, S_VAR, S_START_SD, S_SD_DIV, S_SD_SQRT, S_RM_DIV, S_RM_SQRT,
    S_CLS_FAST, S_CLS_SLOW, S_CLS_COV, S_CLS_END, S_DONE
  } state_e;

  function automatic logic [IntervalW-1:0] abs_diff(input logic [IntervalW-1:0] a,
                                                    input logic [IntervalW-1:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

  state_e               state_q;
  logic [IntervalW-1:0] win_mem [WINDOW_DEPTH];
  logic [IntervalW-1:0] rd_data_q;
  logic [PtrW-1:0]      rd_addr;
  logic [PtrW-1:0]      wp_prev;
  logic [PtrW-1:0]      wp_next;
  logic                 win_we;

  logic [PtrW-1:0]      wp_q;
  logic [CntW-1:0]      fill_q;
  logic [SumW-1:0]      sum_q;
  logic [SqW-1:0]       sq_q;
  logic [SqW-1:0]       dsq_q;
  logic [IntervalW-1:0] x_q;
  logic [IntervalW-1:0] prev_q;
  logic [IntervalW-1:0] old_q;
  logic [IntervalW-1:0] nxt_q;
  logic [VarW-1:0]      nsq_q;
  logic [VarW-1:0]      var_q;
  logic [RtW-1:0]       sd_q;
  logic [PrdW-1:0]      sdn_q;
  logic                 fast_q;
  logic                 slow_q;
  logic [PrdW-1:0]      mul_q;
  out_item_t            res_q;
  out_item_t            out_q;
  logic                 out_valid_q;

  logic [MulW-1:0]      mul_a;
  logic [MulW-1:0]      mul_b;
  logic [PrdW-1:0]      mul_p;
  logic [VarW-1:0]      nsq_p;
  logic                 full;
  logic                 valid_fill;
  logic [ClassW-1:0]    rhythm_c;
  logic [ClassW-1:0]    stress_c;

  logic                 ds_start;
  ds_op_e               ds_op;
  logic [DvW-1:0]       ds_a;
  logic [DsW-1:0]       ds_b;
  logic                 ds_done;
  logic [DvW-1:0]       ds_quo;
  logic [RtW-1:0]       ds_root;

  hrvw_divsqrt #(
    .DvW (DvW),
    .DsW (DsW)
  ) u_divsqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ds_start),
    .op_i    (ds_op),
    .a_i     (ds_a),
    .b_i     (ds_b),
    .done_o  (ds_done),
    .quo_o   (ds_quo),
    .root_o  (ds_root)
  );

  assign full       = (fill_q == CntW'(WINDOW_DEPTH));
  assign valid_fill = (32'(fill_q) >= 32'(MIN_INTERVALS));
  assign wp_prev    = (wp_q == '0) ? PtrW'(WINDOW_DEPTH - 1) : wp_q - 1'b1;
  assign wp_next    = (wp_q == PtrW'(WINDOW_DEPTH - 1)) ? '0 : wp_q + 1'b1;
  assign win_we     = (state_q == S_UPD_NXT);
  assign mul_p      = mul_a * mul_b;
  assign nsq_p      = fill_q * sq_q;

  assign pop_ready_o  = (state_q == S_IDLE);
  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_q;

  always_comb begin
    case (state_q)
      S_RD_PREV: rd_addr = wp_prev;
      S_RD_NXT:  rd_addr = wp_next;
      default:   rd_addr = wp_q;
    endcase
  end

  // shared multiplier, operands picked by step, product registered
  always_comb begin
    case (state_q)
      S_RD_OLD: begin
        mul_a = MulW'(x_q);
        mul_b = MulW'(x_q);
      end
      S_RD_NXT: begin
        mul_a = MulW'(abs_diff(x_q, prev_q));
        mul_b = MulW'(abs_diff(x_q, prev_q));
      end
      S_UPD_PREV: begin
        mul_a = MulW'(old_q);
        mul_b = MulW'(old_q);
      end
      S_UPD_OLD: begin
        mul_a = MulW'(abs_diff(nxt_q, old_q));
        mul_b = MulW'(abs_diff(nxt_q, old_q));
      end
      S_STAT: begin
        mul_a = MulW'(sum_q);
        mul_b = MulW'(sum_q);
      end
      S_VAR: begin
        mul_a = MulW'(fill_q);
        mul_b = MulW'(fill_q);
      end
      S_RM_SQRT: begin
        mul_a = MulW'(cfg_i.fast_mean_limit);
        mul_b = MulW'(fill_q);
      end
      S_CLS_FAST: begin
        mul_a = MulW'(cfg_i.slow_mean_limit);
        mul_b = MulW'(fill_q);
      end
      S_CLS_SLOW: begin
        mul_a = MulW'(sd_q[SdW-1:0]);
        mul_b = MulW'(fill_q);
      end
      S_CLS_COV: begin
        mul_a = MulW'(cfg_i.variation_limit);
        mul_b = MulW'(sum_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    ds_start = 1'b0;
    ds_op    = OP_DIV;
    ds_a     = '0;
    ds_b     = '0;
    case (state_q)
      S_START_SD: begin
        ds_start = 1'b1;
        ds_a     = {var_q, SqFracShift'(0)};
        ds_b     = mul_q[DsW-1:0];
      end
      S_SD_DIV, S_RM_DIV: begin
        ds_start = ds_done;
        ds_op    = OP_SQRT;
        ds_a     = ds_quo;
      end
      S_SD_SQRT: begin
        ds_start = ds_done;
        ds_a     = DvW'({dsq_q, SqFracShift'(0)});
        ds_b     = DsW'(fill_q) - DsW'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    if (sum_q == '0) begin
      rhythm_c = RHYTHM_NORMAL;
    end else if (fast_q) begin
      rhythm_c = RHYTHM_TACHY;
    end else if (slow_q) begin
      rhythm_c = RHYTHM_BRADY;
    end else if ((CmpW'(sdn_q) << CovShift) > CmpW'(mul_q)) begin
      rhythm_c = RHYTHM_IRREGULAR;
    end else begin
      rhythm_c = RHYTHM_NORMAL;
    end
    if (sd_q >= (RtW'(cfg_i.low_stress_sdnn) << SixteenthShift)) begin
      stress_c = STRESS_LOW;
    end else if (sd_q >= (RtW'(cfg_i.moderate_stress_sdnn) << SixteenthShift)) begin
      stress_c = STRESS_MODERATE;
    end else if (sd_q >= (RtW'(cfg_i.high_stress_sdnn) << SixteenthShift)) begin
      stress_c = STRESS_HIGH;
    end else begin
      stress_c = STRESS_VERY_HIGH;
    end
  end

  always_ff @(posedge clk_i) begin
    if (win_we) begin
      win_mem[wp_q] <= x_q;
    end
    rd_data_q <= win_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wp_q        <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      sq_q        <= '0;
      dsq_q       <= '0;
      x_q         <= '0;
      prev_q      <= '0;
      old_q       <= '0;
      nxt_q       <= '0;
      nsq_q       <= '0;
      var_q       <= '0;
      sd_q        <= '0;
      sdn_q       <= '0;
      fast_q      <= 1'b0;
      slow_q      <= 1'b0;
      mul_q       <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mul_q <= mul_p;
      if ((state_q == S_DONE) && (!out_valid_q || out_if.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (pop_valid_i) begin
            x_q     <= pop_item_i.interval_ms;
            res_q   <= '{accepted: pop_item_i.accepted, default: '0};
            state_q <= pop_item_i.accepted ? S_RD_PREV : S_STAT;
          end
        end
        S_RD_PREV: state_q <= S_RD_OLD;
        S_RD_OLD: begin
          prev_q  <= rd_data_q;
          state_q <= S_RD_NXT;
        end
        S_RD_NXT: begin
          old_q   <= rd_data_q;
          sq_q    <= sq_q + SqW'(mul_q[2*IntervalW-1:0]);
          sum_q   <= sum_q + SumW'(x_q);
          state_q <= S_UPD_PREV;
        end
        S_UPD_PREV: begin
          nxt_q <= rd_data_q;
          if (fill_q != '0) begin
            dsq_q <= dsq_q + SqW'(mul_q[2*IntervalW-1:0]);
          end
          state_q <= S_UPD_OLD;
        end
        S_UPD_OLD: begin
          if (full) begin
            sq_q  <= sq_q - SqW'(mul_q[2*IntervalW-1:0]);
            sum_q <= sum_q - SumW'(old_q);
          end
          state_q <= S_UPD_NXT;
        end
        S_UPD_NXT: begin
          // oldest pair leaves the difference sum once the window wraps
          if (full) begin
            dsq_q <= dsq_q - SqW'(mul_q[2*IntervalW-1:0]);
          end else begin
            fill_q <= fill_q + 1'b1;
          end
          wp_q    <= wp_next;
          state_q <= S_STAT;
        end
        S_STAT: begin
          if (valid_fill) begin
            res_q.valid_res <= 1'b1;
            nsq_q           <= nsq_p;
            state_q         <= S_VAR;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_VAR: begin
          var_q   <= nsq_q - mul_q[VarW-1:0];
          state_q <= S_START_SD;
        end
        S_START_SD: state_q <= S_SD_DIV;
        S_SD_DIV: begin
          if (ds_done) state_q <= S_SD_SQRT;
        end
        S_SD_SQRT: begin
          if (ds_done) begin
            sd_q                  <= ds_root;
            res_q.sdnn_sixteenths <= ds_root[SdW-1:0];
            state_q               <= S_RM_DIV;
          end
        end
        S_RM_DIV: begin
          if (ds_done) state_q <= S_RM_SQRT;
        end
        S_RM_SQRT: begin
          if (ds_done) begin
            res_q.rmssd_sixteenths <= ds_root[SdW-1:0];
            state_q                <= S_CLS_FAST;
          end
        end
        S_CLS_FAST: begin
          fast_q  <= PrdW'(sum_q) < mul_q;
          state_q <= S_CLS_SLOW;
        end
        S_CLS_SLOW: begin
          slow_q  <= PrdW'(sum_q) > mul_q;
          state_q <= S_CLS_COV;
        end
        S_CLS_COV: begin
          sdn_q   <= mul_q;
          state_q <= S_CLS_END;
        end
        S_CLS_END: begin
          res_q.rhythm_class <= rhythm_c;
          res_q.stress_class <= stress_c;
          state_q            <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || out_if.ready) begin
            out_q   <= res_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `HRVW_ASSERT(a_fill_bound, 32'(fill_q) <= WINDOW_DEPTH, "fill count beyond window depth")
  `HRVW_ASSERT(a_wp_tracks_fill, !full |-> (CntW'(wp_q) == fill_q), "write pointer off fill count")
  `HRVW_ASSERT(a_invalid_is_zero, (out_valid_q && !out_q.valid_res) |-> (out_q.sdnn_sixteenths == '0 && out_q.stress_class == '0), "stats set on an invalid result")
  `HRVW_ASSERT_NEVER(a_ds_done_idle, ds_done && (state_q == S_IDLE), "divider finished with no item in work")
endmodule

[src/heart_rate_variability_window.sv]
// path: an accepted item updates the window sums; once the window is valid, SDNN and
//   RMSSD each take a divide and then a root on the shared bit-serial divide/root unit,
//   then the rhythm and stress classes follow; a dropped item skips the window update
// flow: one item in work at a time; the input queue holds two items meanwhile
// reset: rst_ni asynchronous, active low; registers to their reset values, sums and
//   counts to zero; window contents stay undefined, no clearing pass is needed
module heart_rate_variability_window #(
  parameter int unsigned WINDOW_DEPTH  = 32,
  parameter int unsigned MIN_INTERVALS = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [hrvw_pkg::RegIdxW-1:0] cfg_idx_i,
  input  logic [hrvw_pkg::RegW-1:0]    cfg_data_i,
  hrvw_stream_if.sink                  in_if,
  hrvw_stream_if.source                out_if
);
  import hrvw_pkg::*;

  logic        push_valid;
  logic        push_ready;
  queue_item_t push_item;
  logic        pop_valid;
  logic        pop_ready;
  queue_item_t pop_item;
  cfg_regs_t   cfg;

  hrvw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_if        (in_if),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item),
    .cfg_o        (cfg)
  );

  hrvw_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  hrvw_back #(
    .WINDOW_DEPTH  (WINDOW_DEPTH),
    .MIN_INTERVALS (MIN_INTERVALS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .cfg_i       (cfg),
    .out_if      (out_if)
  );
endmodule

[tb/sv/hrvw_window_checker.sv]
`timescale 1ns / 1ps

module hrvw_window_checker #(
  parameter int unsigned WINDOW_DEPTH  = 32,
  parameter int unsigned MIN_INTERVALS = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [hrvw_pkg::RegIdxW-1:0] cfg_idx_i,
  input  logic [hrvw_pkg::RegW-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  hrvw_pkg::in_item_t           in_data_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  hrvw_pkg::out_item_t          out_data_i,
  output int                           fail_count_o,
  output int                           pending_o
);
  import hrvw_pkg::*;

  cfg_regs_t   cfg;
  logic [15:0] window_q [WINDOW_DEPTH];
  int unsigned wr_pos;
  int unsigned fill;
  longint unsigned sum_x, sum_xx, sum_dd;
  out_item_t   stats_q [$];

  assign pending_o = stats_q.size();

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned sq_gap(logic [15:0] a, logic [15:0] b);
    longint unsigned d;
    d = (a > b) ? a - b : b - a;
    return d * d;
  endfunction

  function automatic out_item_t window_stats(logic [15:0] x);
    out_item_t       r;
    longint unsigned n, sd, var_num;
    int unsigned     prev;
    r = '0;
    if (x >= cfg.min_interval && x <= cfg.max_interval) begin
      r.accepted = 1'b1;
      if (fill >= WINDOW_DEPTH) begin
        sum_x  -= window_q[wr_pos];
        sum_xx -= longint'(window_q[wr_pos]) * window_q[wr_pos];
        sum_dd -= sq_gap(window_q[(wr_pos + 1) % WINDOW_DEPTH], window_q[wr_pos]);
      end
      if (fill >= 1) begin
        prev = (wr_pos + WINDOW_DEPTH - 1) % WINDOW_DEPTH;
        sum_dd += sq_gap(x, window_q[prev]);
      end
      window_q[wr_pos] = x;
      sum_x  += x;
      sum_xx += longint'(x) * x;
      wr_pos = (wr_pos + 1) % WINDOW_DEPTH;
      if (fill < WINDOW_DEPTH) fill++;
    end
    if (fill >= MIN_INTERVALS && fill >= 1) begin
      n = fill;
      var_num = n * sum_xx - sum_x * sum_x;
      sd = int_sqrt((var_num * 256) / (n * n));
      r.valid_res = 1'b1;
      r.sdnn_sixteenths = sd[SdW-1:0];
      if (n >= 2) r.rmssd_sixteenths = SdW'(int_sqrt((sum_dd * 256) / (n - 1)));
      r.rhythm_class = RHYTHM_NORMAL;
      if (sum_x != 0) begin
        if (sum_x < longint'(cfg.fast_mean_limit) * n) r.rhythm_class = RHYTHM_TACHY;
        else if (sum_x > longint'(cfg.slow_mean_limit) * n) r.rhythm_class = RHYTHM_BRADY;
        else if (sd * n * 4096 > longint'(cfg.variation_limit) * sum_x)
          r.rhythm_class = RHYTHM_IRREGULAR;
      end
      if (sd >= longint'(cfg.low_stress_sdnn) * 16) r.stress_class = STRESS_LOW;
      else if (sd >= longint'(cfg.moderate_stress_sdnn) * 16) r.stress_class = STRESS_MODERATE;
      else if (sd >= longint'(cfg.high_stress_sdnn) * 16) r.stress_class = STRESS_HIGH;
      else r.stress_class = STRESS_VERY_HIGH;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      cfg <= CfgReset;
      wr_pos = 0;
      fill = 0;
      sum_x = 0;
      sum_xx = 0;
      sum_dd = 0;
      fail_count_o <= 0;
      stats_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_MIN_INTERVAL:    cfg.min_interval         <= cfg_data_i;
          REG_MAX_INTERVAL:    cfg.max_interval         <= cfg_data_i;
          REG_FAST_MEAN:       cfg.fast_mean_limit      <= cfg_data_i;
          REG_SLOW_MEAN:       cfg.slow_mean_limit      <= cfg_data_i;
          REG_VARIATION:       cfg.variation_limit      <= cfg_data_i;
          REG_LOW_STRESS:      cfg.low_stress_sdnn      <= cfg_data_i;
          REG_MODERATE_STRESS: cfg.moderate_stress_sdnn <= cfg_data_i;
          REG_HIGH_STRESS:     cfg.high_stress_sdnn     <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) stats_q.push_back(window_stats(in_data_i.interval_ms));
      if (out_valid_i && out_ready_i) begin
        if (stats_q.size() == 0) begin
          $display("%0t: unexpected item %p", $time, out_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = stats_q.pop_front();
          if (want !== out_data_i) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, out_data_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

[tb/sv/tb_heart_rate_variability_window.sv]
`timescale 1ns / 1ps

module tb_heart_rate_variability_window;
  import hrvw_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [RegIdxW-1:0] cfg_idx_i = '0;
  logic [RegW-1:0]    cfg_data_i = '0;
  int                 fail_count, pending;
  bit                 sending_done = 1'b0;
  bit                 hold_off = 1'b0;

  hrvw_stream_if #(.item_t(in_item_t))  in_ch ();
  hrvw_stream_if #(.item_t(out_item_t)) out_ch ();

  always #4 clk_i = ~clk_i;

  heart_rate_variability_window u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_if(in_ch.sink), .out_if(out_ch.source)
  );

  hrvw_window_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i(in_ch.valid), .in_ready_i(in_ch.ready), .in_data_i(in_ch.data),
    .out_valid_i(out_ch.valid), .out_ready_i(out_ch.ready), .out_data_i(out_ch.data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 400) : $urandom_range(0, 2);
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [RegW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic send_interval(logic [15:0] ms);
    in_ch.valid <= 1'b1;
    in_ch.data  <= ms;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    in_ch.valid <= 1'b0;
    repeat (gap_len()) @(posedge clk_i);
  endtask

  // rhythm-like interval with random spread, occasional noise over the whole range
  function automatic logic [15:0] heartbeat(int unsigned base, int unsigned spread);
    if ($urandom_range(0, 9) == 0) return 16'($urandom());
    return 16'(base + $urandom_range(0, spread));
  endfunction

  task automatic drain_and_settle();
    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: fill to valid, field extremes, default thresholds
    send_interval(16'd0);
    send_interval(16'hFFFF);
    send_interval(16'd249);
    send_interval(16'd2001);
    send_interval(16'd250);
    send_interval(16'd2000);
    for (int i = 0; i < 12; i++) send_interval(16'(800 + 3 * i));
    send_interval(16'd300);
    send_interval(16'd1900);
    drain_and_settle();

    // inverted range: nothing accepted
    write_reg(REG_MIN_INTERVAL, 16'd3000);
    write_reg(REG_MAX_INTERVAL, 16'd100);
    for (int i = 0; i < 4; i++) send_interval(16'(i * 900));
    drain_and_settle();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_MIN_INTERVAL, 16'd0);
          write_reg(REG_MAX_INTERVAL, 16'hFFFF);
          write_reg(REG_FAST_MEAN, 16'd0);
          write_reg(REG_SLOW_MEAN, 16'hFFFF);
          write_reg(REG_VARIATION, 16'd0);
          write_reg(REG_LOW_STRESS, 16'hFFFF);
          write_reg(REG_MODERATE_STRESS, 16'hFFFF);
          write_reg(REG_HIGH_STRESS, 16'hFFFF);
        end
        1: begin
          write_reg(REG_FAST_MEAN, 16'hFFFF);
          write_reg(REG_VARIATION, 16'hFFFF);
          write_reg(REG_LOW_STRESS, 16'd0);
        end
        2: begin
          write_reg(REG_MIN_INTERVAL, 16'd250);
          write_reg(REG_MAX_INTERVAL, 16'd2000);
          write_reg(REG_FAST_MEAN, 16'd500);
          write_reg(REG_SLOW_MEAN, 16'd1200);
          write_reg(REG_VARIATION, 16'd11796);
          write_reg(REG_LOW_STRESS, 16'd50);
          write_reg(REG_MODERATE_STRESS, 16'd30);
          write_reg(REG_HIGH_STRESS, 16'd20);
        end
        3: begin
          write_reg(REG_FAST_MEAN, 16'd0);
          write_reg(REG_SLOW_MEAN, 16'd0);
        end
        default: begin
          write_reg(REG_SLOW_MEAN, 16'hFFFF);
          write_reg(REG_VARIATION, 16'd3000);
          write_reg(REG_LOW_STRESS, 16'd200);
          write_reg(REG_MODERATE_STRESS, 16'd80);
          write_reg(REG_HIGH_STRESS, 16'd10);
        end
      endcase
      for (int i = 0; i < 76; i++) begin
        case ($urandom_range(0, 3))
          0: send_interval(heartbeat(400, 60));
          1: send_interval(heartbeat(800, 400));
          2: send_interval(heartbeat(1300, 40));
          default: send_interval(heartbeat(250, 1750));
        endcase
      end
      drain_and_settle();
    end
    sending_done = 1'b1;
  end

  // sink side with random stalls and one long hold-off while items keep coming
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) out_ch.ready <= 1'b0;
      else out_ch.ready <= ($urandom_range(0, 9) < 6) || ($urandom_range(0, 1) == 0);
    end
  end

  initial begin
    @(posedge rst_ni);
    repeat (3000) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (2500) @(posedge clk_i);
    hold_off = 1'b0;
  end

  initial begin
    wait (sending_done);
    if (fail_count == 0) $display("heart_rate_variability_window regression: pass");
    else $display("heart_rate_variability_window regression: fail");
    $finish;
  end

  initial begin
    #40ms;
    $display("heart_rate_variability_window regression: fail");
    $finish;
  end
endmodule
